// File: rtl/core/longest_prefix_route_table_defines.svh
// assertion macros for the route table
`ifndef LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH

`ifndef SYNTH
// cond holds in the same cycle as trig
`define LPRT_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("lprt assertion failed");
// cond holds in the cycle after trig
`define LPRT_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("lprt assertion failed");
`else
`define LPRT_ASSERT_SAME(label, trig, cond)
`define LPRT_ASSERT_NEXT(label, trig, cond)
`endif

`endif

// File: rtl/core/lprt_pkg.sv
package lprt_pkg;

   localparam int MAX_ROUTES = 16;
   localparam int MAX_PORTS  = 8;
   localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
   localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int ADDR_W     = 32;
   localparam int PFX_W      = 6;
   localparam int PORT_W     = 4;
   localparam int FULL_PFX   = 32;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_DUP     = 3'd1,
      ST_INVALID = 3'd2,
      ST_FULL    = 3'd3,
      ST_FOUND   = 3'd4,
      ST_NOROUTE = 3'd5
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] net;
      logic [PFX_W-1:0]  prefix;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } route_type;

   // add: route key; lookup: best match so far
   typedef struct packed {
      logic              valid;
      logic              op;
      logic              bad;
      logic              hit;
      logic [CNT_W-1:0]  left;
      logic [ADDR_W-1:0] addr;
      logic [PFX_W-1:0]  prefix;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } token_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] len);
      logic [ADDR_W-1:0] m;
      if (len == '0) begin
         m = '0;
      end else if (len >= PFX_W'(FULL_PFX)) begin
         m = '1;
      end else begin
         m = ~({ADDR_W{1'b1}} >> len);
      end
      return m;
   endfunction

endpackage

// File: rtl/core/lprt_cell.sv
module lprt_cell import lprt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  token_type up_tok,
   input  logic      wr_sel,
   input  route_type wr_route,
   output token_type dn_tok
);

   token_type         tok_ff, tok_in;
   logic [ADDR_W-1:0] net_ff;
   logic [PFX_W-1:0]  pfx_ff;
   logic [ADDR_W-1:0] hop_ff;
   logic [PORT_W-1:0] port_ff;
   logic [ADDR_W-1:0] mask;
   logic              active;

   always_comb begin
      tok_in = up_tok;
      mask   = prefix_mask(pfx_ff);
      active = up_tok.valid && !up_tok.bad && (up_tok.left != '0);
      if (active) begin
         tok_in.left = up_tok.left - CNT_W'(1);
         if (up_tok.op == OP_ADD) begin
            if (port_ff == up_tok.port && pfx_ff == up_tok.prefix &&
                net_ff == up_tok.addr && hop_ff == up_tok.hop) begin
               tok_in.hit = 1'b1;
            end
         end else begin
            if (((up_tok.addr & mask) == net_ff) &&
                (!up_tok.hit || pfx_ff > up_tok.prefix)) begin
               tok_in.hit    = 1'b1;
               tok_in.prefix = pfx_ff;
               tok_in.hop    = hop_ff;
               tok_in.port   = port_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         net_ff  <= wr_route.net;
         pfx_ff  <= wr_route.prefix;
         hop_ff  <= wr_route.hop;
         port_ff <= wr_route.port;
      end
   end

   assign dn_tok = tok_ff;

endmodule

// File: rtl/core/longest_prefix_route_table.sv
// IPv4 route table with longest-prefix-match lookup.
// input: start with req_operation (add or lookup) and the route fields; an item
// is taken at a clock edge where start is high and busy is low. busy stays high
// until the item's result is out.
// result: rsp_valid is high for exactly one cycle with rsp_status and the
// matched route fields; the receiver cannot hold it off.
// each item walks a row of MAX_ROUTES cells, one cell per cycle, each cell
// holding one route; lookups keep the longest match, adds look for a duplicate.
// each cell registers the item in turn, and rsp_valid is registered from
// the last cell's output. the walk along the cell row holds off a new item
// until the result is out; start may be taken in the cycle rsp_valid is high.
// an added route is written into the next free cell at the result edge.
// config: APB register 0 (byte address 0) is num_ports, 4 bits, reset 8.
// reset clears the route count, busy and the result strobe; cell contents
// are left as they are and are never read until written.
module longest_prefix_route_table import lprt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [ADDR_W-1:0]   req_dest_addr,
   input  logic [PFX_W-1:0]    req_prefix_len,
   input  logic [ADDR_W-1:0]   req_hop_addr,
   input  logic [PORT_W-1:0]   req_out_port,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [ADDR_W-1:0]   rsp_route_hop,
   output logic [PORT_W-1:0]   rsp_route_port,
   output logic [PFX_W-1:0]    rsp_route_prefix,
   output logic                rsp_is_direct,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

`include "longest_prefix_route_table_defines.svh"

   token_type             chain [MAX_ROUTES+1];
   logic [MAX_ROUTES-1:0] chain_valid;
   token_type             fin;

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PORT_W-1:0]     num_ports_ff;
   logic                  rsp_valid_ff;
   status_type            status_ff, status_in;
   logic [ADDR_W-1:0]     hop_ff, hop_in;
   logic [PORT_W-1:0]     port_ff, port_in;
   logic [PFX_W-1:0]      pfx_ff, pfx_in;
   logic                  direct_ff, direct_in;

   logic                  accept;
   logic [PORT_W-1:0]     limit;
   logic                  bad_add;
   logic                  wr_en;
   logic                  full;
   logic                  cfg_wr;
   route_type             wr_route;

   assign accept = start && !busy_ff;
   assign limit  = (num_ports_ff > PORT_W'(MAX_PORTS)) ? PORT_W'(MAX_PORTS) : num_ports_ff;
   assign bad_add = (req_out_port == '0) || (req_out_port > limit) ||
                    (req_prefix_len > PFX_W'(FULL_PFX));

   always_comb begin
      chain[0]       = '0;
      chain[0].valid = accept;
      chain[0].op    = req_operation;
      chain[0].left  = count_ff;
      if (req_operation == OP_ADD) begin
         chain[0].bad    = bad_add;
         chain[0].addr   = req_dest_addr & prefix_mask(req_prefix_len);
         chain[0].prefix = req_prefix_len;
         chain[0].hop    = req_hop_addr;
         chain[0].port   = req_out_port;
      end else begin
         chain[0].addr   = req_dest_addr;
      end
   end

   assign wr_route.net    = fin.addr;
   assign wr_route.prefix = fin.prefix;
   assign wr_route.hop    = fin.hop;
   assign wr_route.port   = fin.port;

   for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
      lprt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_tok   (chain[i]),
         .wr_sel   (wr_en && (count_ff[IDX_W-1:0] == IDX_W'(i))),
         .wr_route (wr_route),
         .dn_tok   (chain[i+1])
      );
      assign chain_valid[i] = chain[i+1].valid;
   end

   assign fin  = chain[MAX_ROUTES];
   assign full = (count_ff == CNT_W'(MAX_ROUTES));
   assign wr_en = fin.valid && (fin.op == OP_ADD) && !fin.bad && !fin.hit && !full;

   always_comb begin
      hop_in    = '0;
      port_in   = '0;
      pfx_in    = '0;
      direct_in = 1'b0;
      if (fin.op == OP_ADD) begin
         priority if (fin.bad) begin
            status_in = ST_INVALID;
         end else if (fin.hit) begin
            status_in = ST_DUP;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ADDED;
         end
      end else if (fin.hit) begin
         status_in = ST_FOUND;
         hop_in    = fin.hop;
         port_in   = fin.port;
         pfx_in    = fin.prefix;
         direct_in = (fin.hop == '0);
      end else begin
         status_in = ST_NOROUTE;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (fin.valid) begin
         busy_in = 1'b0;
      end
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.valid) begin
         status_ff <= status_in;
         hop_ff    <= hop_in;
         port_ff   <= port_in;
         pfx_ff    <= pfx_in;
         direct_ff <= direct_in;
      end
   end

   // config transfer
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ports_ff <= PORT_W'(MAX_PORTS);
      end else if (cfg_wr && (paddr[2] == 1'b0)) begin
         num_ports_ff <= pwdata[PORT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == 1'b0) ? 32'(num_ports_ff) : '0;
   assign pready = 1'b1;

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_route_hop    = hop_ff;
   assign rsp_route_port   = port_ff;
   assign rsp_route_prefix = pfx_ff;
   assign rsp_is_direct    = direct_ff;

   `LPRT_ASSERT_NEXT(a_accept_busy, accept, busy_ff)
   `LPRT_ASSERT_SAME(a_one_in_row, 1'b1, $onehot0(chain_valid))
   `LPRT_ASSERT_SAME(a_row_busy, chain_valid != '0, busy_ff)
   `LPRT_ASSERT_NEXT(a_count_step, wr_en, count_ff == $past(count_ff) + CNT_W'(1))
   `LPRT_ASSERT_SAME(a_count_max, 1'b1, count_ff <= CNT_W'(MAX_ROUTES))

endmodule
